// ===== src/b2s_pkg.sv =====
// b2s_pkg: constants, types and helpers for the blake2s hash engine
// no dependencies; used by controller, datapath and top level

package b2s_pkg;

    localparam int unsigned WordW = 32;

    localparam logic [31:0] ParamWord = 32'h0101_0000;

    typedef logic [31:0] t_word;

    function automatic t_word iv_word(input logic [2:0] idx);
        t_word res;
        case (idx)
            3'd0:    res = 32'h6A09E667;
            3'd1:    res = 32'hBB67AE85;
            3'd2:    res = 32'h3C6EF372;
            3'd3:    res = 32'hA54FF53A;
            3'd4:    res = 32'h510E527F;
            3'd5:    res = 32'h9B05688C;
            3'd6:    res = 32'h1F83D9AB;
            default: res = 32'h5BE0CD19;
        endcase
        return res;
    endfunction

    // message schedule: sigma[round][pos]
    function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] pos);
        logic [63:0] row;
        case (rnd)
            4'd0:    row = 64'hFEDCBA9876543210;
            4'd1:    row = 64'h357B20C16DF984AE;
            4'd2:    row = 64'h491763EADF250C8B;
            4'd3:    row = 64'h8F04A562EBCD1397;
            4'd4:    row = 64'hD386CB1EFA427509;
            4'd5:    row = 64'h91EF57D438B0A6C2;
            4'd6:    row = 64'hB8293670A4DEF15C;
            4'd7:    row = 64'hA2684F05931CE7BD;
            4'd8:    row = 64'h5A417D2C803B9EF6;
            default: row = 64'h0DC3E9BF5167482A;
        endcase
        return row[pos*4 +: 4];
    endfunction

    // working vector indexes for each of the eight g steps in a round
    function automatic logic [15:0] g_idx(input logic [2:0] g);
        logic [15:0] res;
        case (g)
            3'd0:    res = {4'd12, 4'd8, 4'd4, 4'd0};
            3'd1:    res = {4'd13, 4'd9, 4'd5, 4'd1};
            3'd2:    res = {4'd14, 4'd10, 4'd6, 4'd2};
            3'd3:    res = {4'd15, 4'd11, 4'd7, 4'd3};
            3'd4:    res = {4'd15, 4'd10, 4'd5, 4'd0};
            3'd5:    res = {4'd12, 4'd11, 4'd6, 4'd1};
            3'd6:    res = {4'd13, 4'd8, 4'd7, 4'd2};
            default: res = {4'd14, 4'd9, 4'd4, 4'd3};
        endcase
        return res;
    endfunction

    function automatic logic [5:0] eff_len(input logic [5:0] d);
        logic [5:0] res;
        if (d == 6'd0) begin
            res = 6'd1;
        end else if (d > 6'd32) begin
            res = 6'd32;
        end else begin
            res = d;
        end
        return res;
    endfunction

    // controller commands to the datapath
    typedef struct packed {
        logic       init;       // restart message: chain from iv, clear counts
        logic       put;        // pack accepted word
        logic       pre_cmp;    // fill block with the bytes that fit, flush it
        logic       fin;        // finalize: add count, pad
        logic       load_v;     // load working vector
        logic       g_half;     // second half of g
        logic       g_step;     // perform a g half step
        logic       feed;       // fold working vector into chain
        logic       last_flag;  // final block flag for load
    } t_cmd;

    typedef struct packed {
        logic over;     // bytes of the offered word overflow the block
    } t_stat;

endpackage

// ===== src/b2s_datapath.sv =====
// b2s_datapath: block buffer, counter, working vector and shared g unit
// depends on b2s_pkg

module b2s_datapath import b2s_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [3:0]  i_round,
    input  logic [2:0]  i_g,
    input  logic [5:0]  i_len,
    input  logic [31:0] i_data,
    input  logic [2:0]  i_nbytes,
    input  logic [2:0]  i_rd_idx,
    output t_stat       o_stat,
    output t_word       o_chain
);

    t_word      r_m [16];
    t_word      r_v [16];
    t_word      r_h [8];
    logic [6:0] r_cnt;
    logic [1:0] r_skip;
    logic [63:0] r_ctr;

    logic [15:0] idx;
    logic [3:0]  ia, ib, ic, id;
    t_word       a, b, c, d, mw, a1, d1, c1, b1;
    logic [3:0]  mi;
    logic [6:0]  fit, put_cnt;
    logic [6:0]  pre_pos [4];
    logic [6:0]  put_pos [4];
    logic [2:0]  nb;

    assign idx = g_idx(i_g);
    assign ia = idx[3:0];
    assign ib = idx[7:4];
    assign ic = idx[11:8];
    assign id = idx[15:12];
    assign mi = sigma(i_round, {i_g, i_cmd.g_half});

    always_comb begin
        a  = r_v[ia];
        b  = r_v[ib];
        c  = r_v[ic];
        d  = r_v[id];
        mw = r_m[mi];
        a1 = a + b + mw;
        if (!i_cmd.g_half) begin
            d1 = d ^ a1;
            d1 = {d1[15:0], d1[31:16]};
            c1 = c + d1;
            b1 = b ^ c1;
            b1 = {b1[11:0], b1[31:12]};
        end else begin
            d1 = d ^ a1;
            d1 = {d1[7:0], d1[31:8]};
            c1 = c + d1;
            b1 = b ^ c1;
            b1 = {b1[6:0], b1[31:7]};
        end
    end

    assign nb = (i_nbytes > 3'd4) ? 3'd4 : i_nbytes;
    assign fit = 7'd64 - r_cnt;
    // bytes already packed before the flush are skipped on the later put
    assign put_cnt = r_cnt + {4'd0, nb} - {5'd0, r_skip};
    assign o_stat.over = ((r_cnt + {4'd0, nb}) > 7'd64);
    assign o_chain = r_h[i_rd_idx];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pre_pos[k] = r_cnt + 7'(k);
            put_pos[k] = r_cnt + 7'(k) - {5'd0, r_skip};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_skip <= '0;
            r_ctr  <= '0;
            for (int i = 1; i < 8; i++) begin
                r_h[i] <= iv_word(3'(i));
            end
            r_h[0] <= iv_word(3'd0) ^ ParamWord ^ 32'd32;
        end else begin
            if (i_cmd.init) begin
                r_cnt  <= '0;
                r_skip <= '0;
                r_ctr  <= '0;
                for (int i = 1; i < 8; i++) begin
                    r_h[i] <= iv_word(3'(i));
                end
                r_h[0] <= iv_word(3'd0) ^ ParamWord ^ {26'd0, eff_len(i_len)};
            end
            if (i_cmd.pre_cmp) begin
                for (int k = 0; k < 4; k++) begin
                    if (7'(k) < fit && 3'(k) < nb) begin
                        r_m[pre_pos[k][5:2]][pre_pos[k][1:0]*8 +: 8] <= i_data[k*8 +: 8];
                    end
                end
                r_skip <= fit[1:0];
                r_ctr  <= r_ctr + 64'd64;
                r_cnt  <= '0;
            end
            if (i_cmd.put) begin
                for (int k = 0; k < 4; k++) begin
                    if (3'(k) >= {1'b0, r_skip} && 3'(k) < nb) begin
                        r_m[put_pos[k][5:2]][put_pos[k][1:0]*8 +: 8] <= i_data[k*8 +: 8];
                    end
                end
                r_cnt  <= put_cnt;
                r_skip <= '0;
            end
            if (i_cmd.fin) begin
                r_ctr <= r_ctr + {57'd0, put_cnt};
                for (int i = 0; i < 64; i++) begin
                    if (7'(i) >= put_cnt) begin
                        r_m[i/4][(i%4)*8 +: 8] <= 8'd0;
                    end
                end
            end
            if (i_cmd.load_v) begin
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_h[i];
                end
                for (int i = 0; i < 4; i++) begin
                    r_v[i+8] <= iv_word(3'(i));
                end
                r_v[12] <= iv_word(3'd4) ^ r_ctr[31:0];
                r_v[13] <= iv_word(3'd5) ^ r_ctr[63:32];
                r_v[14] <= iv_word(3'd6) ^ {32{i_cmd.last_flag}};
                r_v[15] <= iv_word(3'd7);
            end
            if (i_cmd.g_step) begin
                r_v[ia] <= a1;
                r_v[ib] <= b1;
                r_v[ic] <= c1;
                r_v[id] <= d1;
            end
            if (i_cmd.feed) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] ^ r_v[i] ^ r_v[i+8];
                end
            end
        end
    end

endmodule

// ===== src/b2s_ctrl.sv =====
// b2s_ctrl: sequencer for packing, compression and digest output
// depends on b2s_pkg

module b2s_ctrl import b2s_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_in_valid,
    input  logic       i_in_last,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  logic [5:0] i_len,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic [3:0] o_round,
    output logic [2:0] o_g,
    output logic [2:0] o_rd_idx,
    output logic       o_out_last,
    output logic [1:0] o_rem
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_RUN, S_FEED, S_OUT
    } t_state;

    t_state     r_state;
    logic [3:0] r_round;
    logic [2:0] r_g;
    logic       r_half;
    logic       r_final;
    logic [2:0] r_idx;
    logic [5:0] len;
    logic [2:0] nwords_m1;
    logic       accept;

    assign len = eff_len(i_len);
    assign nwords_m1 = 3'((len - 6'd1) >> 2);
    assign o_rem = len[1:0];
    assign o_in_ready = (r_state == S_IDLE) && !i_stat.over;
    assign accept = o_in_ready && i_in_valid;
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_last = (r_idx == nwords_m1);
    assign o_rd_idx = r_idx;
    assign o_round = r_round;
    assign o_g = r_g;

    always_comb begin
        o_cmd = '0;
        o_cmd.g_half = r_half;
        o_cmd.last_flag = r_final;
        o_cmd.init = i_cfg_we;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.over) begin
                    o_cmd.pre_cmp = 1'b1;
                end else if (accept) begin
                    o_cmd.put = 1'b1;
                    o_cmd.fin = i_in_last;
                end
            end
            S_LOAD: o_cmd.load_v = 1'b1;
            S_RUN:  o_cmd.g_step = 1'b1;
            S_FEED: o_cmd.feed = 1'b1;
            S_OUT: begin
                if (i_out_ready && o_out_last) begin
                    o_cmd.init = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // a word whose bytes overflow the block fills it and is held by not
    // asserting ready until the compression returns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_round    <= '0;
            r_g        <= '0;
            r_half     <= 1'b0;
            r_final    <= 1'b0;
            r_idx      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_stat.over) begin
                        r_state    <= S_LOAD;
                        r_final    <= 1'b0;
                    end else if (accept && i_in_last) begin
                        r_state    <= S_LOAD;
                        r_final    <= 1'b1;
                    end
                end
                S_LOAD: begin
                    r_state <= S_RUN;
                    r_round <= '0;
                    r_g     <= '0;
                    r_half  <= 1'b0;
                end
                S_RUN: begin
                    r_half <= ~r_half;
                    if (r_half) begin
                        r_g <= r_g + 3'd1;
                        if (r_g == 3'd7) begin
                            r_round <= r_round + 4'd1;
                            if (r_round == 4'd9) begin
                                r_state <= S_FEED;
                            end
                        end
                    end
                end
                S_FEED: begin
                    r_idx <= '0;
                    r_state <= r_final ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (o_out_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/blake2s_hash_engine_core.sv =====
// Unkeyed BLAKE2s engine. Words are packed into a 64-byte block; when the
// bytes of an offered word would overflow the block, the bytes that fit
// are packed, the block is compressed and the word waits until compression ends
// before it is accepted with its remaining bytes. The last word triggers
// padding and a final compression, then ceil(len/4) digest words come
// out one per accepted cycle. Other words are accepted while idle.
// Compression time is set by the single shared g unit: 160 half-g steps
// per block. Writing the digest length restarts the current message.
// top level: instantiates b2s_ctrl and b2s_datapath, uses b2s_pkg

module blake2s_hash_engine_core import b2s_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_word[31:0], valid_bytes[34:32], zeros
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zeros
    output logic        m_axis_tlast
);

    logic [5:0] r_len;
    t_cmd       cmd;
    t_stat      stat;
    logic [3:0] rnd;
    logic [2:0] g, rd_idx;
    logic [1:0] rem;
    t_word      chain, outw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 6'd32;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    b2s_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we,
        .i_in_valid(s_axis_tvalid),
        .i_in_last(s_axis_tlast), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_len(i_cfg_we ? i_cfg_data : r_len), .i_stat(stat), .o_cmd(cmd),
        .o_round(rnd), .o_g(g), .o_rd_idx(rd_idx), .o_out_last(m_axis_tlast),
        .o_rem(rem)
    );

    b2s_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_round(rnd), .i_g(g),
        .i_len(i_cfg_we ? i_cfg_data : r_len), .i_data(s_axis_tdata[31:0]),
        .i_nbytes(s_axis_tdata[34:32]), .i_rd_idx(rd_idx),
        .o_stat(stat), .o_chain(chain)
    );

    always_comb begin
        outw = chain;
        if (m_axis_tlast) begin
            case (rem)
                2'd1:    outw = {24'd0, chain[7:0]};
                2'd2:    outw = {16'd0, chain[15:0]};
                2'd3:    outw = {8'd0, chain[23:0]};
                default: outw = chain;
            endcase
        end
    end

    assign m_axis_tdata = {5'd0, rd_idx, outw};

endmodule

// ===== src/b2s_checker.sv =====
// b2s_checker: port-level checks for the blake2s engine
// depends on nothing; bound to blake2s_hash_engine_core

module b2s_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while digest pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest request dropped");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
        else $error("digest index skipped");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
        else $error("pad bits set");

endmodule

bind blake2s_hash_engine_core b2s_checker u_chk (.*);
